// ===== src/angle_binned_weight_histogram_unit_assert.svh =====
// Assertion macros shared by the histogram unit RTL.
`ifndef ANGLE_BINNED_WEIGHT_HISTOGRAM_UNIT_ASSERT_SVH
`define ANGLE_BINNED_WEIGHT_HISTOGRAM_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABWH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABWH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/abwh_pkg.sv =====
// Shared types, constants and the square-root helper function of the histogram unit.
`timescale 1ns / 1ps
`default_nettype none
package abwh_pkg;

	localparam int SUM_W   = 48;
	localparam int BIN_W   = 8;
	localparam int Q16_ONE = 65536;

	typedef enum logic [1:0] {
		KIND_NORM,
		KIND_ZERO,
		KIND_SKIP,
		KIND_ADD
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BIN_W-1:0]   bin;
		logic [2:0]         ord;
		logic [4:0]         ext;
		logic [1:0]         ch;
		logic signed [31:0] wd;
		logic signed [31:0] we;
		logic signed [31:0] fc;
	} work_t;

	typedef struct packed {
		logic [3:0]       angle_bin;
		logic [SUM_W-1:0] order_sum_dir;
		logic [SUM_W-1:0] order_sum_ex;
		logic [SUM_W-1:0] total_sum_dir;
		logic [SUM_W-1:0] total_sum_ex;
		logic [SUM_W-1:0] norm_sum;
		logic             zero_vector;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] n;
		logic [SUM_W-1:0] r;
	} sqrt_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_SQRT,
		F_DEN,
		F_DIV0,
		F_DIV,
		F_BIN,
		F_SEND
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC,
		B_RDZ,
		B_WRO,
		B_WRZ,
		B_PUSH
	} back_state_t;

	// One step of the digit-by-digit integer square root.
	function automatic sqrt_t sqrt_step(input logic [SUM_W-1:0] n,
	                                    input logic [SUM_W-1:0] r,
	                                    input logic [SUM_W-1:0] b);
		sqrt_t            res;
		logic [SUM_W-1:0] trial;
		trial = r + b;
		if (n >= trial) begin
			res.n = n - trial;
			res.r = (r >> 1) + b;
		end else begin
			res.n = n;
			res.r = r >> 1;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== src/abwh_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module abwh_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/abwh_fifo.sv =====
// Small register FIFO used between the stages and at the result side.
`timescale 1ns / 1ps
`default_nettype none
module abwh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rdata
);
	`include "angle_binned_weight_histogram_unit_assert.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ABWH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "fifo count beyond depth")
	`ABWH_ASSERT_NEXT(a_cnt_inc, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "fifo push lost")
	`ABWH_ASSERT_NEXT(a_cnt_dec, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1, "fifo pop lost")
endmodule
`default_nettype wire

// ===== src/abwh_front.sv =====
// Front end: accept item, form cosine iteratively, classify into a work beat.
`timescale 1ns / 1ps
`default_nettype none
module abwh_front #(
	parameter int ANGLE_BINS   = 16,
	parameter int EXT_MOM_BINS = 32,
	parameter int ORDER_SLOTS  = 8,
	parameter int CHANNELS     = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               hold,
	input  wire logic signed [23:0] left_x,
	input  wire logic signed [23:0] left_y,
	input  wire logic signed [23:0] left_z,
	input  wire logic signed [23:0] right_x,
	input  wire logic signed [23:0] right_y,
	input  wire logic signed [23:0] right_z,
	input  wire logic [4:0]         ext_mom_bin,
	input  wire logic [2:0]         order,
	input  wire logic [1:0]         channel,
	input  wire logic signed [31:0] weight_dir,
	input  wire logic signed [31:0] weight_ex,
	input  wire logic signed [31:0] factor,
	output logic                    wq_push,
	input  wire logic               wq_full,
	output abwh_pkg::work_t         wq_data
);
	import abwh_pkg::*;

	localparam int PW = 18 + $clog2(ANGLE_BINS) + 1;

	front_state_t       state_q, state_d;
	logic signed [23:0] lx_q, ly_q, lz_q, rx_q, ry_q, rz_q;
	logic signed [23:0] ma, mb;
	logic signed [47:0] prod_q;
	logic [3:0]         k_q;
	logic signed [49:0] dot_q;
	logic [SUM_W-1:0]   na_q, nb_q, ra_q, rb_q, bit_q;
	logic [SUM_W-1:0]   den_q, rem_q;
	logic [48:0]        mag_q, rem2;
	logic [16:0]        q_q, qc;
	logic [4:0]         cnt_q;
	logic [17:0]        tval;
	logic [PW-1:0]      scaled;
	logic [BIN_W-1:0]   bin_calc;
	logic               skip_idx;
	sqrt_t              sa, sb;
	work_t              item_q;
	logic               accept;

	assign accept = push && !full;

	always_comb begin
		unique case (k_q)
			4'd0:    begin ma = lx_q; mb = rx_q; end
			4'd1:    begin ma = ly_q; mb = ry_q; end
			4'd2:    begin ma = lz_q; mb = rz_q; end
			4'd3:    begin ma = lx_q; mb = lx_q; end
			4'd4:    begin ma = ly_q; mb = ly_q; end
			4'd5:    begin ma = lz_q; mb = lz_q; end
			4'd6:    begin ma = rx_q; mb = rx_q; end
			4'd7:    begin ma = ry_q; mb = ry_q; end
			4'd8:    begin ma = rz_q; mb = rz_q; end
			default: begin ma = '0;   mb = '0;   end
		endcase
	end

	assign sa   = sqrt_step(na_q, ra_q, bit_q);
	assign sb   = sqrt_step(nb_q, rb_q, bit_q);
	assign rem2 = {rem_q, 1'b0};
	assign skip_idx = (32'(item_q.ord) >= ORDER_SLOTS) || (32'(item_q.ext) >= EXT_MOM_BINS) ||
	                  (32'(item_q.ch) >= CHANNELS);

	// Clamp the cosine at one, offset to [0, 2] and scale to the bin count.
	always_comb begin
		qc       = (q_q > 17'(Q16_ONE)) ? 17'(Q16_ONE) : q_q;
		tval     = dot_q[49] ? (18'(Q16_ONE) - 18'(qc)) : (18'(Q16_ONE) + 18'(qc));
		scaled   = PW'(tval) * PW'(ANGLE_BINS);
		bin_calc = ((scaled >> 17) >= PW'(ANGLE_BINS)) ? BIN_W'(ANGLE_BINS - 1)
		                                                : BIN_W'(scaled >> 17);
	end

	always_comb begin
		state_d = state_q;
		full    = (state_q != F_IDLE) || hold;
		wq_push = 1'b0;
		wq_data = item_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (order == 3'd0) ? F_SEND : F_MUL;
				end
			end
			F_MUL: begin
				if (k_q == 4'd9) begin
					state_d = F_SQRT;
				end
			end
			F_SQRT: begin
				if (bit_q == SUM_W'(1)) begin
					state_d = F_DEN;
				end
			end
			F_DEN:  state_d = F_DIV0;
			F_DIV0: begin
				if (den_q == '0) begin
					state_d = F_SEND;
				end else if (mag_q >= {den_q, 1'b0}) begin
					state_d = F_BIN;
				end else begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (cnt_q == '0) begin
					state_d = F_BIN;
				end
			end
			F_BIN:  state_d = F_SEND;
			F_SEND: begin
				wq_push = !wq_full;
				if (!wq_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				lx_q   <= left_x;
				ly_q   <= left_y;
				lz_q   <= left_z;
				rx_q   <= right_x;
				ry_q   <= right_y;
				rz_q   <= right_z;
				item_q <= '{kind: KIND_NORM, bin: '0, ord: order, ext: ext_mom_bin,
				            ch: channel, wd: weight_dir, we: weight_ex, fc: factor};
				k_q    <= '0;
				dot_q  <= '0;
				na_q   <= '0;
				nb_q   <= '0;
			end
			F_MUL: begin
				prod_q <= ma * mb;
				k_q    <= k_q + 1'b1;
				if (k_q != 4'd0) begin
					if (k_q <= 4'd3) begin
						dot_q <= dot_q + 50'(prod_q);
					end else if (k_q <= 4'd6) begin
						na_q <= na_q + prod_q[47:0];
					end else begin
						nb_q <= nb_q + prod_q[47:0];
					end
				end
				ra_q  <= '0;
				rb_q  <= '0;
				bit_q <= SUM_W'(1) << 46;
			end
			F_SQRT: begin
				na_q  <= sa.n;
				ra_q  <= sa.r;
				nb_q  <= sb.n;
				rb_q  <= sb.r;
				bit_q <= bit_q >> 2;
			end
			F_DEN: begin
				den_q <= SUM_W'(ra_q[23:0] * rb_q[23:0]);
				mag_q <= dot_q[49] ? 49'(-dot_q) : 49'(dot_q);
			end
			F_DIV0: begin
				item_q.kind <= KIND_ZERO;
				cnt_q       <= 5'd15;
				if (mag_q >= {den_q, 1'b0}) begin
					q_q <= 17'(Q16_ONE);
				end else if (mag_q >= {1'b0, den_q}) begin
					q_q   <= 17'd1;
					rem_q <= SUM_W'(mag_q - {1'b0, den_q});
				end else begin
					q_q   <= 17'd0;
					rem_q <= mag_q[47:0];
				end
			end
			F_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= SUM_W'(rem2 - {1'b0, den_q});
					q_q   <= {q_q[15:0], 1'b1};
				end else begin
					rem_q <= rem2[47:0];
					q_q   <= {q_q[15:0], 1'b0};
				end
			end
			F_BIN: begin
				item_q <= '{kind: (skip_idx ? KIND_SKIP : KIND_ADD), bin: bin_calc,
				            ord: item_q.ord, ext: item_q.ext, ch: item_q.ch,
				            wd: item_q.wd, we: item_q.we, fc: item_q.fc};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/abwh_back.sv =====
// Back end: clear the sum memory, then apply each add beat by read-modify-write.
`timescale 1ns / 1ps
`default_nettype none
module abwh_back #(
	parameter int ANGLE_BINS   = 16,
	parameter int EXT_MOM_BINS = 32,
	parameter int ORDER_SLOTS  = 8,
	parameter int CHANNELS     = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	output logic            clearing,
	input  wire logic       wq_empty,
	output logic            wq_pop,
	input  abwh_pkg::work_t wq_data,
	input  wire logic       rq_full,
	output logic            rq_push,
	output abwh_pkg::result_t rq_data
);
	import abwh_pkg::*;
	`include "angle_binned_weight_histogram_unit_assert.svh"

	localparam int ROWS = ORDER_SLOTS * ANGLE_BINS * EXT_MOM_BINS * CHANNELS;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RW   = 2 * SUM_W;

	back_state_t        state_q, state_d;
	work_t              it_q;
	logic [AW-1:0]      clr_q, row_o, row_z;
	logic [SUM_W-1:0]   pd_q, pe_q, norm_q;
	logic [RW-1:0]      so_q, sz_q, ram_rdata, ram_wdata;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic               ram_we;
	logic signed [63:0] pdw, pew;
	logic [SUM_W-1:0]   fc_ext;
	result_t            res_q, res_d;

	// Row holds the exchange sum in the upper half, the direct sum in the lower.
	assign row_o = AW'((((32'(it_q.ord) * ANGLE_BINS + 32'(it_q.bin)) * EXT_MOM_BINS
	                 + 32'(it_q.ext)) * CHANNELS) + 32'(it_q.ch));
	assign row_z = AW'(((32'(it_q.bin) * EXT_MOM_BINS + 32'(it_q.ext)) * CHANNELS)
	                 + 32'(it_q.ch));
	assign pdw    = it_q.wd * it_q.fc;
	assign pew    = it_q.we * it_q.fc;
	assign fc_ext = {{(SUM_W - 32){it_q.fc[31]}}, it_q.fc};
	assign clearing = (state_q == B_CLEAR);
	assign rq_data  = res_q;

	abwh_ram #(
		.WIDTH(RW),
		.DEPTH(ROWS)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		wq_pop    = 1'b0;
		rq_push   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = row_o;
		ram_wdata = so_q;
		ram_raddr = row_o;
		unique case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(ROWS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				wq_pop = !wq_empty;
				if (!wq_empty) begin
					state_d = B_EXEC;
				end
			end
			B_EXEC: state_d = (it_q.kind == KIND_ADD) ? B_RDZ : B_PUSH;
			B_RDZ: begin
				ram_raddr = row_z;
				state_d   = B_WRO;
			end
			B_WRO: begin
				ram_we  = 1'b1;
				state_d = B_WRZ;
			end
			B_WRZ: begin
				ram_we    = 1'b1;
				ram_waddr = row_z;
				ram_wdata = sz_q;
				state_d   = B_PUSH;
			end
			B_PUSH: begin
				rq_push = !rq_full;
				if (!rq_full) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Build the result beat: fields at execute, sums once both rows are written.
	always_comb begin
		res_d = res_q;
		case (state_q)
			B_EXEC: begin
				res_d          = '0;
				res_d.norm_sum = norm_q;
				case (it_q.kind)
					KIND_NORM: res_d.norm_sum    = norm_q + fc_ext;
					KIND_ZERO: res_d.zero_vector = 1'b1;
					KIND_SKIP: res_d.angle_bin   = it_q.bin[3:0];
					default:   res_d.angle_bin   = it_q.bin[3:0];
				endcase
			end
			B_WRZ: begin
				res_d.order_sum_dir = so_q[SUM_W-1:0];
				res_d.order_sum_ex  = so_q[RW-1:SUM_W];
				res_d.total_sum_dir = sz_q[SUM_W-1:0];
				res_d.total_sum_ex  = sz_q[RW-1:SUM_W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			norm_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == B_EXEC && it_q.kind == KIND_NORM) begin
				norm_q <= norm_q + fc_ext;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		case (state_q)
			B_IDLE: it_q <= wq_data;
			B_EXEC: begin
				pd_q <= pdw[SUM_W-1:0];
				pe_q <= pew[SUM_W-1:0];
			end
			B_RDZ: begin
				so_q <= {ram_rdata[RW-1:SUM_W] + pe_q, ram_rdata[SUM_W-1:0] + pd_q};
			end
			B_WRO: begin
				sz_q <= {ram_rdata[RW-1:SUM_W] + pe_q, ram_rdata[SUM_W-1:0] + pd_q};
			end
			default: ;
		endcase
	end

	`ABWH_ASSERT_NOW(a_no_pop_in_clear, state_q == B_CLEAR, !wq_pop, "beat taken during clear")
	`ABWH_ASSERT_NEXT(a_pop_to_exec, wq_pop, state_q == B_EXEC, "popped beat not executed")
	`ABWH_ASSERT_NOW(a_rows_differ, state_q == B_WRZ, ram_waddr != $past(ram_waddr), "row collision")
endmodule
`default_nettype wire

// ===== src/angle_binned_weight_histogram_unit.sv =====
// Order-0 items skip the cosine math; other items go through the front end's shared
// multiplier (10 steps), square root (24) and divider (17), one item at a time.
// Back end takes one work beat at a time and needs two row read-modify-writes
// on one RAM per update beat.
// Reset: asynchronous, clears control; then a clearing pass over all
// ORDER_SLOTS*ANGLE_BINS*EXT_MOM_BINS*CHANNELS rows (16384 by default) holds full.
`timescale 1ns / 1ps
`default_nettype none
module angle_binned_weight_histogram_unit #(
	parameter int ANGLE_BINS   = 16,
	parameter int EXT_MOM_BINS = 32,
	parameter int ORDER_SLOTS  = 8,
	parameter int CHANNELS     = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input side, a queue push port
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [23:0] left_x,
	input  wire logic signed [23:0] left_y,
	input  wire logic signed [23:0] left_z,
	input  wire logic signed [23:0] right_x,
	input  wire logic signed [23:0] right_y,
	input  wire logic signed [23:0] right_z,
	input  wire logic [4:0]         ext_mom_bin,
	input  wire logic [2:0]         order,
	input  wire logic [1:0]         channel,
	input  wire logic signed [31:0] weight_dir,
	input  wire logic signed [31:0] weight_ex,
	input  wire logic signed [31:0] factor,
	// result side, a queue pop port
	output logic                    empty,
	input  wire logic               pop,
	output logic [3:0]              angle_bin,
	output logic signed [47:0]      order_sum_dir,
	output logic signed [47:0]      order_sum_ex,
	output logic signed [47:0]      total_sum_dir,
	output logic signed [47:0]      total_sum_ex,
	output logic signed [47:0]      norm_sum,
	output logic                    zero_vector
);
	import abwh_pkg::*;

	// Work beats between front and back; results wait in their own queue so the
	// back end can go on while the consumer stalls.
	work_t   wq_wdata, wq_rdata;
	result_t rq_wdata, rq_rdata;
	logic    wq_push, wq_full, wq_pop, wq_empty;
	logic    rq_push, rq_full;
	logic    clearing;

	abwh_front #(
		.ANGLE_BINS  (ANGLE_BINS),
		.EXT_MOM_BINS(EXT_MOM_BINS),
		.ORDER_SLOTS (ORDER_SLOTS),
		.CHANNELS    (CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hold       (clearing),
		.left_x     (left_x),
		.left_y     (left_y),
		.left_z     (left_z),
		.right_x    (right_x),
		.right_y    (right_y),
		.right_z    (right_z),
		.ext_mom_bin(ext_mom_bin),
		.order      (order),
		.channel    (channel),
		.weight_dir (weight_dir),
		.weight_ex  (weight_ex),
		.factor     (factor),
		.wq_push    (wq_push),
		.wq_full    (wq_full),
		.wq_data    (wq_wdata)
	);

	abwh_fifo #(
		.WIDTH($bits(work_t)),
		.DEPTH(2)
	) u_work_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (wq_push),
		.full  (wq_full),
		.wdata (wq_wdata),
		.pop   (wq_pop),
		.empty (wq_empty),
		.rdata (wq_rdata)
	);

	abwh_back #(
		.ANGLE_BINS  (ANGLE_BINS),
		.EXT_MOM_BINS(EXT_MOM_BINS),
		.ORDER_SLOTS (ORDER_SLOTS),
		.CHANNELS    (CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.clearing(clearing),
		.wq_empty(wq_empty),
		.wq_pop  (wq_pop),
		.wq_data (wq_rdata),
		.rq_full (rq_full),
		.rq_push (rq_push),
		.rq_data (rq_wdata)
	);

	abwh_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.full  (rq_full),
		.wdata (rq_wdata),
		.pop   (pop),
		.empty (empty),
		.rdata (rq_rdata)
	);

	// Oldest result beat drives the ports while empty is low.
	assign angle_bin     = rq_rdata.angle_bin;
	assign order_sum_dir = rq_rdata.order_sum_dir;
	assign order_sum_ex  = rq_rdata.order_sum_ex;
	assign total_sum_dir = rq_rdata.total_sum_dir;
	assign total_sum_ex  = rq_rdata.total_sum_ex;
	assign norm_sum      = rq_rdata.norm_sum;
	assign zero_vector   = rq_rdata.zero_vector;
endmodule
`default_nettype wire
